### rtl/sced_pkg.sv
// Shared types and constants for the spectrum channel energy detector.
// No dependencies; every other file in rtl imports this package.
package sced_pkg;

   // fixed field widths
   localparam int POWER_W     = 16;
   localparam int FRAME_W     = 12;
   localparam int CHAN_W      = 5;
   localparam int CHAN_IDX_W  = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // reset values
   localparam logic signed [POWER_W-1:0] POWER_FLOOR          = -16'sd25600;
   localparam logic signed [CHAN_W-1:0]  NO_CHANNEL           = -5'sd1;
   localparam logic [FRAME_W-1:0]        FRAME_LENGTH_RESET   = 12'd511;
   localparam logic signed [POWER_W-1:0] MAIN_THRESHOLD_RESET = -16'sd17920;
   localparam logic signed [POWER_W-1:0] EDGE_THRESHOLD_RESET = -16'sd15360;

   // control register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_LENGTH   = 2'd0,
      CSR_MAIN_THRESHOLD = 2'd1,
      CSR_EDGE_THRESHOLD = 2'd2
   } sced_csr_type;

   // events raised by one bin
   typedef struct packed {
      logic main_close;
      logic edge_close;
      logic frame_end;
   } sced_flags_type;

   // averaged window results handed to the decision stage
   typedef struct packed {
      sced_flags_type              flags;
      logic [CHAN_W-1:0]           main_ch;
      logic signed [POWER_W-1:0]   main_avg;
      logic signed [POWER_W-1:0]   edge_avg;
   } sced_avg_type;

endpackage

### rtl/sced_window_accum.sv
// Bin counter, window position tracking and window accumulators.
// Depends on sced_pkg; emits one event per bin that closes a window or ends a frame.
module sced_window_accum #(
   parameter int WINDOW_WIDTH  = 41,
   parameter int START_OFFSET  = 10,
   parameter int FIRST_CHANNEL = 5,
   parameter int NUM_CHANNELS  = 15,
   parameter int EDGE_OFFSET   = 10,
   parameter int MAX_BINS      = 4096,
   parameter int SUM_W         = 22
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [sced_pkg::POWER_W-1:0]      req_bin_power,
   input  logic                                     req_last_bin,
   input  logic [sced_pkg::FRAME_W-1:0]             frame_length,
   output logic                                     evt_valid,
   input  logic                                     evt_ready,
   output sced_pkg::sced_flags_type                 evt_flags,
   output logic [sced_pkg::CHAN_W-1:0]              evt_main_ch,
   output logic signed [SUM_W-1:0]                  evt_main_sum,
   output logic signed [SUM_W-1:0]                  evt_edge_sum
);
   import sced_pkg::*;

   localparam int CNT_W   = $clog2(MAX_BINS);
   localparam int POS_W   = (WINDOW_WIDTH > 1) ? $clog2(WINDOW_WIDTH) : 1;
   localparam int MAIN_LO = WINDOW_WIDTH + START_OFFSET;
   localparam int MAIN_HI = MAIN_LO + (NUM_CHANNELS - 1 - FIRST_CHANNEL) * WINDOW_WIDTH;
   localparam int CMP_W   = $clog2(MAX_BINS + 4096 + (NUM_CHANNELS + 2) * WINDOW_WIDTH
                                   + START_OFFSET + EDGE_OFFSET) + 2;
   localparam logic signed [CMP_W-1:0] MAIN_LO_S = CMP_W'(MAIN_LO);
   localparam logic signed [CMP_W-1:0] MAIN_HI_S = CMP_W'(MAIN_HI);
   localparam logic signed [CMP_W-1:0] EDGE_SPAN = CMP_W'(2 * WINDOW_WIDTH + EDGE_OFFSET);
   localparam logic signed [CMP_W-1:0] WIN_LAST  = CMP_W'(WINDOW_WIDTH - 1);
   localparam logic [CNT_W-1:0]        CNT_LAST  = CNT_W'(MAX_BINS - 1);
   localparam logic [POS_W-1:0]        POS_LAST  = POS_W'(WINDOW_WIDTH - 1);

   logic [CNT_W-1:0]        bin_count_ff, bin_count_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CHAN_W-1:0]       chan_ff, chan_in;
   logic signed [SUM_W-1:0] main_sum_ff, main_sum_in;
   logic signed [SUM_W-1:0] edge_sum_ff, edge_sum_in;
   logic                    evt_valid_ff;
   sced_flags_type          evt_flags_ff, evt_flags_in;
   logic [CHAN_W-1:0]       evt_main_ch_ff;
   logic signed [SUM_W-1:0] evt_main_sum_ff, evt_edge_sum_ff;

   logic signed [CMP_W-1:0] idx, edge_lo, edge_end;
   logic                    in_main, in_edge, main_start;
   logic [POS_W-1:0]        cur_pos;
   logic [CHAN_W-1:0]       cur_ch;
   logic signed [SUM_W-1:0] p_ext;
   logic                    accept, evt_adv;

   // handshake with the event register
   assign evt_adv   = !evt_valid_ff || evt_ready;
   assign req_ready = evt_adv;
   assign accept    = req_valid && evt_adv;

   // window placement and accumulation for the current bin
   always_comb begin
      idx        = $signed(CMP_W'(bin_count_ff));
      edge_lo    = $signed(CMP_W'(frame_length)) - EDGE_SPAN;
      edge_end   = edge_lo + WIN_LAST;
      in_main    = (idx >= MAIN_LO_S) && (idx < MAIN_HI_S);
      in_edge    = !edge_lo[CMP_W-1] && (idx >= edge_lo) && (idx <= edge_end);
      main_start = (idx == MAIN_LO_S);
      cur_pos    = main_start ? '0 : pos_ff;
      cur_ch     = main_start ? CHAN_W'(FIRST_CHANNEL) : chan_ff;
      p_ext      = SUM_W'(req_bin_power);

      evt_flags_in.main_close = in_main && (cur_pos == POS_LAST);
      evt_flags_in.edge_close = in_edge && (idx == edge_end);
      evt_flags_in.frame_end  = req_last_bin;

      main_sum_in  = (cur_pos == '0) ? p_ext : main_sum_ff + p_ext;
      edge_sum_in  = (idx == edge_lo) ? p_ext : edge_sum_ff + p_ext;
      pos_in       = evt_flags_in.main_close ? '0 : cur_pos + 1'b1;
      chan_in      = evt_flags_in.main_close ? cur_ch + 1'b1 : cur_ch;
      bin_count_in = (bin_count_ff == CNT_LAST) ? '0 : bin_count_ff + 1'b1;
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= '0;
         pos_ff       <= '0;
         chan_ff      <= CHAN_W'(FIRST_CHANNEL);
         main_sum_ff  <= '0;
         edge_sum_ff  <= '0;
      end else if (accept) begin
         if (req_last_bin) begin
            bin_count_ff <= '0;
            pos_ff       <= '0;
            chan_ff      <= CHAN_W'(FIRST_CHANNEL);
            main_sum_ff  <= '0;
            edge_sum_ff  <= '0;
         end else begin
            bin_count_ff <= bin_count_in;
            if (in_main) begin
               pos_ff      <= pos_in;
               chan_ff     <= chan_in;
               main_sum_ff <= main_sum_in;
            end
            if (in_edge) begin
               edge_sum_ff <= edge_sum_in;
            end
         end
      end
   end

   // event register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else if (evt_adv) begin
         evt_valid_ff <= accept && (evt_flags_in.main_close || evt_flags_in.edge_close
                                    || evt_flags_in.frame_end);
      end
   end

   // event register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         evt_flags_ff    <= evt_flags_in;
         evt_main_ch_ff  <= cur_ch;
         evt_main_sum_ff <= main_sum_in;
         evt_edge_sum_ff <= edge_sum_in;
      end
   end

   assign evt_valid    = evt_valid_ff;
   assign evt_flags    = evt_flags_ff;
   assign evt_main_ch  = evt_main_ch_ff;
   assign evt_main_sum = evt_main_sum_ff;
   assign evt_edge_sum = evt_edge_sum_ff;

   // the end of a frame always restarts the bin counter
   assert property (@(posedge clock) disable iff (reset)
      accept && req_last_bin |=> bin_count_ff == '0)
      else $error("bin counter not cleared after last bin");

   // position inside a main window never reaches the window width
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("window position out of range");

endmodule

### rtl/sced_window_avg.sv
// Window average stage: divides both window sums by the window width.
// Depends on sced_pkg; the division is a reciprocal multiply with truncation toward zero.
module sced_window_avg #(
   parameter int WINDOW_WIDTH = 41,
   parameter int SUM_W        = 22
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          evt_valid,
   output logic                          evt_ready,
   input  sced_pkg::sced_flags_type      evt_flags,
   input  logic [sced_pkg::CHAN_W-1:0]   evt_main_ch,
   input  logic signed [SUM_W-1:0]       evt_main_sum,
   input  logic signed [SUM_W-1:0]       evt_edge_sum,
   output logic                          avg_valid,
   input  logic                          avg_ready,
   output sced_pkg::sced_avg_type        avg_data
);
   import sced_pkg::*;

   // exact for every magnitude below 2**SUM_W
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam int SHIFT  = SUM_W + $clog2(WINDOW_WIDTH);
   localparam logic [SUM_W:0] RECIP =
      (SUM_W+1)'(((64'd1 << SHIFT) + 64'(WINDOW_WIDTH) - 64'd1) / 64'(WINDOW_WIDTH));

   logic         avg_valid_ff;
   sced_avg_type avg_ff, avg_in;
   logic         adv;

   function automatic logic signed [POWER_W-1:0] window_average(
      input logic signed [SUM_W-1:0] sum);
      logic [SUM_W-1:0]  mag;
      logic [PROD_W-1:0] prod;
      logic [SUM_W-1:0]  quo;
      logic [SUM_W-1:0]  res;
      mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      prod = PROD_W'(mag) * PROD_W'(RECIP);
      quo  = SUM_W'(prod >> SHIFT);
      res  = sum[SUM_W-1] ? -quo : quo;
      return res[POWER_W-1:0];
   endfunction

   assign adv       = !avg_valid_ff || avg_ready;
   assign evt_ready = adv;

   // averages of both windows
   always_comb begin
      avg_in.flags    = evt_flags;
      avg_in.main_ch  = evt_main_ch;
      avg_in.main_avg = window_average(evt_main_sum);
      avg_in.edge_avg = window_average(evt_edge_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= 1'b0;
      end else if (adv) begin
         avg_valid_ff <= evt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && evt_valid) begin
         avg_ff <= avg_in;
      end
   end

   assign avg_valid = avg_valid_ff;
   assign avg_data  = avg_ff;

endmodule

### rtl/sced_channel_eval.sv
// Threshold compare, best channel tracking and the result register.
// Depends on sced_pkg; consumes averaged window events in order.
module sced_channel_eval #(
   parameter int NUM_CHANNELS  = 15
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  avg_valid,
   output logic                                  avg_ready,
   input  sced_pkg::sced_avg_type                avg_data,
   input  logic signed [sced_pkg::POWER_W-1:0]   main_threshold,
   input  logic signed [sced_pkg::POWER_W-1:0]   edge_threshold,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sced_pkg::CHAN_IDX_W-1:0]       rsp_channel_index,
   output logic signed [sced_pkg::POWER_W-1:0]   rsp_channel_power,
   output logic                                  rsp_above_threshold,
   output logic signed [sced_pkg::CHAN_W-1:0]    rsp_strongest_channel,
   output logic                                  rsp_decision_final
);
   import sced_pkg::*;

   localparam logic [CHAN_W-1:0] EDGE_CH = CHAN_W'(NUM_CHANNELS - 1);

   logic signed [POWER_W-1:0] best_power_ff, best_power_in;
   logic signed [CHAN_W-1:0]  best_ch_ff, best_ch_in;
   logic                      rsp_valid_ff;
   logic [CHAN_IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic signed [POWER_W-1:0] rsp_power_ff, rsp_power_in;
   logic                      rsp_above_ff, rsp_above_in;
   logic signed [CHAN_W-1:0]  rsp_det_ff;
   logic                      rsp_final_ff;

   logic                      m_above, m_upd, e_above, e_upd;
   logic signed [POWER_W-1:0] mid_power;
   logic signed [CHAN_W-1:0]  mid_ch;
   logic                      has_out, out_free, take;

   // main channel first, then the edge channel against the updated best
   always_comb begin
      m_above   = avg_data.main_avg > main_threshold;
      m_upd     = avg_data.flags.main_close && m_above && (avg_data.main_avg > best_power_ff);
      mid_power = m_upd ? avg_data.main_avg : best_power_ff;
      mid_ch    = m_upd ? $signed(avg_data.main_ch) : best_ch_ff;

      e_above   = avg_data.edge_avg > edge_threshold;
      e_upd     = avg_data.flags.edge_close && e_above && (avg_data.edge_avg > mid_power);
      best_power_in = e_upd ? avg_data.edge_avg : mid_power;
      best_ch_in    = e_upd ? $signed(EDGE_CH) : mid_ch;

      // edge result wins when both windows close on the same bin
      if (avg_data.flags.edge_close) begin
         rsp_index_in = EDGE_CH[CHAN_IDX_W-1:0];
         rsp_power_in = avg_data.edge_avg;
         rsp_above_in = e_above;
      end else begin
         rsp_index_in = avg_data.main_ch[CHAN_IDX_W-1:0];
         rsp_power_in = avg_data.main_avg;
         rsp_above_in = m_above;
      end
   end

   // events without a result drain even while the result register is full
   assign has_out   = avg_data.flags.main_close || avg_data.flags.edge_close;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = avg_valid && (out_free || !has_out);
   assign avg_ready = out_free || !has_out;

   // best channel state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         best_power_ff <= POWER_FLOOR;
         best_ch_ff    <= NO_CHANNEL;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            if (avg_data.flags.frame_end) begin
               best_power_ff <= POWER_FLOOR;
               best_ch_ff    <= NO_CHANNEL;
            end else begin
               best_power_ff <= best_power_in;
               best_ch_ff    <= best_ch_in;
            end
         end
         if (take && has_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take && has_out) begin
         rsp_index_ff <= rsp_index_in;
         rsp_power_ff <= rsp_power_in;
         rsp_above_ff <= rsp_above_in;
         rsp_det_ff   <= best_ch_in;
         rsp_final_ff <= avg_data.flags.edge_close;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_channel_index     = rsp_index_ff;
   assign rsp_channel_power     = rsp_power_ff;
   assign rsp_above_threshold   = rsp_above_ff;
   assign rsp_strongest_channel = rsp_det_ff;
   assign rsp_decision_final    = rsp_final_ff;

   // a recorded detection always lies above the power floor
   assert property (@(posedge clock) disable iff (reset)
      best_ch_ff != NO_CHANNEL |-> best_power_ff > POWER_FLOOR)
      else $error("detected channel without power above floor");

   // an event that carries a result waits while the result register is held
   assert property (@(posedge clock) disable iff (reset)
      avg_valid && has_out && !out_free |=> avg_valid)
      else $error("window result dropped under back pressure");

endmodule

### rtl/spectrum_channel_energy_detector_unit.sv
// Top level of the spectrum channel energy detector: control registers and pipeline.
// Depends on sced_pkg, sced_window_accum, sced_window_avg and sced_channel_eval.
//
// Usage:
//   req_* carries one log-power bin per request (signed Q7.8 dB) with a last-bin
//   flag. rsp_* gives one result per bin closing a channel averaging window
//   (the edge one if both close): channel number, window average, threshold flag,
//   best channel so far and a final-decision flag on the edge channel result.
//   csr_* writes frame_length, main_threshold and edge_threshold with no wait;
//   write only while no request is in flight.
// Timing:
//   one request per clock while req_ready is high; a result passes through the
//   event register, average register and result register. The path per stage
//   is one accumulate-and-compare, one reciprocal multiply, or one compare
//   chain on the best channel.
// Reset clears the bin counter, the window sums and the best channel, and loads
// the control registers with their defaults. When the receiver stalls, the
// result register holds; bins that raise no event keep flowing until an event
// waits behind a window result that is stuck behind the held one.
module spectrum_channel_energy_detector_unit #(
   parameter int WINDOW_WIDTH  = 41,
   parameter int START_OFFSET  = 10,
   parameter int FIRST_CHANNEL = 5,
   parameter int NUM_CHANNELS  = 15,
   parameter int EDGE_OFFSET   = 10,
   parameter int MAX_BINS      = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [sced_pkg::POWER_W-1:0]   req_bin_power,
   input  logic                                  req_last_bin,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sced_pkg::CHAN_IDX_W-1:0]       rsp_channel_index,
   output logic signed [sced_pkg::POWER_W-1:0]   rsp_channel_power,
   output logic                                  rsp_above_threshold,
   output logic signed [sced_pkg::CHAN_W-1:0]    rsp_strongest_channel,
   output logic                                  rsp_decision_final,
   input  logic                                  csr_write_enable,
   input  logic [sced_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sced_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import sced_pkg::*;

   localparam int SUM_W = POWER_W + $clog2(WINDOW_WIDTH);

   logic [FRAME_W-1:0]        frame_length_ff;
   logic signed [POWER_W-1:0] main_threshold_ff;
   logic signed [POWER_W-1:0] edge_threshold_ff;

   logic                      evt_valid, evt_ready;
   sced_flags_type            evt_flags;
   logic [CHAN_W-1:0]         evt_main_ch;
   logic signed [SUM_W-1:0]   evt_main_sum, evt_edge_sum;
   logic                      avg_valid, avg_ready;
   sced_avg_type              avg_data;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff   <= FRAME_LENGTH_RESET;
         main_threshold_ff <= MAIN_THRESHOLD_RESET;
         edge_threshold_ff <= EDGE_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_LENGTH: begin
               frame_length_ff <= csr_write_data[FRAME_W-1:0];
            end
            CSR_MAIN_THRESHOLD: begin
               main_threshold_ff <= $signed(csr_write_data[POWER_W-1:0]);
            end
            CSR_EDGE_THRESHOLD: begin
               edge_threshold_ff <= $signed(csr_write_data[POWER_W-1:0]);
            end
            default: begin
               frame_length_ff <= frame_length_ff;
            end
         endcase
      end
   end

   // bin counting and window sums
   sced_window_accum #(
      .WINDOW_WIDTH  (WINDOW_WIDTH),
      .START_OFFSET  (START_OFFSET),
      .FIRST_CHANNEL (FIRST_CHANNEL),
      .NUM_CHANNELS  (NUM_CHANNELS),
      .EDGE_OFFSET   (EDGE_OFFSET),
      .MAX_BINS      (MAX_BINS),
      .SUM_W         (SUM_W)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_bin_power (req_bin_power),
      .req_last_bin  (req_last_bin),
      .frame_length  (frame_length_ff),
      .evt_valid     (evt_valid),
      .evt_ready     (evt_ready),
      .evt_flags     (evt_flags),
      .evt_main_ch   (evt_main_ch),
      .evt_main_sum  (evt_main_sum),
      .evt_edge_sum  (evt_edge_sum)
   );

   // window averages
   sced_window_avg #(
      .WINDOW_WIDTH (WINDOW_WIDTH),
      .SUM_W        (SUM_W)
   ) u_avg (
      .clock        (clock),
      .reset        (reset),
      .evt_valid    (evt_valid),
      .evt_ready    (evt_ready),
      .evt_flags    (evt_flags),
      .evt_main_ch  (evt_main_ch),
      .evt_main_sum (evt_main_sum),
      .evt_edge_sum (evt_edge_sum),
      .avg_valid    (avg_valid),
      .avg_ready    (avg_ready),
      .avg_data     (avg_data)
   );

   // thresholds, best channel and result register
   sced_channel_eval #(
      .NUM_CHANNELS  (NUM_CHANNELS)
   ) u_eval (
      .clock                 (clock),
      .reset                 (reset),
      .avg_valid             (avg_valid),
      .avg_ready             (avg_ready),
      .avg_data              (avg_data),
      .main_threshold        (main_threshold_ff),
      .edge_threshold        (edge_threshold_ff),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_channel_index     (rsp_channel_index),
      .rsp_channel_power     (rsp_channel_power),
      .rsp_above_threshold   (rsp_above_threshold),
      .rsp_strongest_channel (rsp_strongest_channel),
      .rsp_decision_final    (rsp_decision_final)
   );

endmodule

### tb/sv/energy_detector_checker.sv
`timescale 1ns / 100ps
// Response checker for the spectrum channel energy detector: follows the bin stream
// and control writes, predicts each closed window and compares every response.
// Depends on sced_pkg for field widths, reset values and control register indexes.
module energy_detector_checker #(
   parameter int WINDOW_WIDTH  = 41,
   parameter int START_OFFSET  = 10,
   parameter int FIRST_CHANNEL = 5,
   parameter int NUM_CHANNELS  = 15,
   parameter int EDGE_OFFSET   = 10,
   parameter int MAX_BINS      = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [sced_pkg::POWER_W-1:0]   req_bin_power,
   input  logic                                  req_last_bin,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [sced_pkg::CHAN_IDX_W-1:0]       rsp_channel_index,
   input  logic signed [sced_pkg::POWER_W-1:0]   rsp_channel_power,
   input  logic                                  rsp_above_threshold,
   input  logic signed [sced_pkg::CHAN_W-1:0]    rsp_strongest_channel,
   input  logic                                  rsp_decision_final,
   input  logic                                  csr_write_enable,
   input  logic [sced_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sced_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output int                                    error_count,
   output int                                    pending_count,
   output int                                    result_count,
   output int                                    edge_count
);
   import sced_pkg::*;

   localparam int SUM_W   = 22;
   localparam int MAIN_LO = WINDOW_WIDTH + START_OFFSET;
   localparam int MAIN_HI = MAIN_LO + (NUM_CHANNELS - 1 - FIRST_CHANNEL) * WINDOW_WIDTH;

   typedef struct packed {
      logic [CHAN_IDX_W-1:0]     channel;
      logic signed [POWER_W-1:0] power;
      logic                      above;
      logic signed [CHAN_W-1:0]  detected;
      logic                      final_flag;
   } window_result_type;

   // windows whose response has not arrived yet, oldest first
   window_result_type closed_windows[$];

   // control register copies
   logic [FRAME_W-1:0]        frame_length;
   logic signed [POWER_W-1:0] main_threshold;
   logic signed [POWER_W-1:0] edge_threshold;

   // frame state
   logic [FRAME_W-1:0]        bin_count;
   logic signed [SUM_W-1:0]   window_sum;
   logic signed [SUM_W-1:0]   edge_sum;
   logic signed [POWER_W-1:0] best_power;
   logic signed [CHAN_W-1:0]  best_channel;

   int errors;
   int results;
   int edges;

   task automatic clear_frame();
      bin_count    = '0;
      window_sum   = '0;
      edge_sum     = '0;
      best_power   = POWER_FLOOR;
      best_channel = NO_CHANNEL;
   endtask

   // threshold test; a qualifying average must also beat the best so far
   function automatic logic qualify(input int avg, input logic signed [POWER_W-1:0] thr,
                                    input int ch);
      logic above;
      above = avg > thr;
      if (above && avg > best_power) begin
         best_power   = POWER_W'(avg);
         best_channel = CHAN_W'(ch);
      end
      return above;
   endfunction

   // advance the frame by one bin and queue the window result it closes, if any
   task automatic predict_window(input logic signed [POWER_W-1:0] p, input logic last);
      int                idx;
      int                off;
      int                pos;
      int                edge_lo;
      int                edge_hi;
      int                m_avg;
      int                m_ch;
      int                e_avg;
      logic              m_above;
      logic              have_main;
      logic              have_edge;
      window_result_type r;
      have_main = 1'b0;
      have_edge = 1'b0;
      m_avg     = 0;
      m_ch      = 0;
      m_above   = 1'b0;
      idx       = int'(bin_count);
      edge_lo   = int'(frame_length) - 2 * WINDOW_WIDTH - EDGE_OFFSET;
      edge_hi   = edge_lo + WINDOW_WIDTH;

      // main channel windows
      if (idx >= MAIN_LO && idx < MAIN_HI) begin
         off = idx - MAIN_LO;
         pos = off % WINDOW_WIDTH;
         window_sum = (pos == 0) ? SUM_W'(p) : window_sum + p;
         if (pos == WINDOW_WIDTH - 1) begin
            m_ch      = FIRST_CHANNEL + off / WINDOW_WIDTH;
            m_avg     = window_sum / WINDOW_WIDTH;
            m_above   = qualify(m_avg, main_threshold, m_ch);
            have_main = 1'b1;
         end
      end

      // edge channel window, evaluated after the main one
      if (edge_lo >= 0 && idx >= edge_lo && idx < edge_hi) begin
         edge_sum = (idx == edge_lo) ? SUM_W'(p) : edge_sum + p;
         if (idx == edge_hi - 1) begin
            e_avg        = edge_sum / WINDOW_WIDTH;
            r.above      = qualify(e_avg, edge_threshold, NUM_CHANNELS - 1);
            r.channel    = CHAN_IDX_W'(NUM_CHANNELS - 1);
            r.power      = POWER_W'(e_avg);
            r.detected   = best_channel;
            r.final_flag = 1'b1;
            closed_windows.push_back(r);
            have_edge = 1'b1;
         end
      end

      // a main close is only reported when the edge window did not close too
      if (!have_edge && have_main) begin
         r.channel    = CHAN_IDX_W'(m_ch);
         r.power      = POWER_W'(m_avg);
         r.above      = m_above;
         r.detected   = best_channel;
         r.final_flag = 1'b0;
         closed_windows.push_back(r);
      end

      if (last) begin
         clear_frame();
      end else begin
         bin_count = FRAME_W'((bin_count + 1) % MAX_BINS);
      end
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, name, expected, actual);
      end
   endtask

   // observe both channels and the control port at each edge
   always @(posedge clock) begin
      window_result_type exp_r;
      if (reset) begin
         frame_length   = FRAME_LENGTH_RESET;
         main_threshold = MAIN_THRESHOLD_RESET;
         edge_threshold = EDGE_THRESHOLD_RESET;
         clear_frame();
         closed_windows.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_LENGTH:   frame_length   = csr_write_data[FRAME_W-1:0];
               CSR_MAIN_THRESHOLD: main_threshold = signed'(csr_write_data);
               CSR_EDGE_THRESHOLD: edge_threshold = signed'(csr_write_data);
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_window(req_bin_power, req_last_bin);
         end
         if (rsp_valid && rsp_ready) begin
            results++;
            if (closed_windows.size() == 0) begin
               errors++;
               $display("%0t ns: response with no window pending, expected none, %s %0d",
                        $time, "actual channel", rsp_channel_index);
            end else begin
               exp_r = closed_windows.pop_front();
               if (exp_r.final_flag) begin
                  edges++;
               end
               check_field("channel_index", int'(exp_r.channel), int'(rsp_channel_index));
               check_field("channel_power", int'($signed(exp_r.power)),
                           int'(rsp_channel_power));
               check_field("above_threshold", int'(exp_r.above), int'(rsp_above_threshold));
               check_field("strongest_channel", int'($signed(exp_r.detected)),
                           int'(rsp_strongest_channel));
               check_field("decision_final", int'(exp_r.final_flag), int'(rsp_decision_final));
            end
         end
      end
      error_count   <= errors;
      pending_count <= closed_windows.size();
      result_count  <= results;
      edge_count    <= edges;
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the energy detector testbench: clock, reset, bin frames, control writes
// and the verdict. Depends on sced_pkg, the detector top and energy_detector_checker.
module testbench;
   import sced_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TOTAL_ITEMS    = 1400;
   localparam int WINDOW         = 41;
   localparam int MAIN_START     = 51;

   typedef enum {PAT_FIXED, PAT_RAMP, PAT_LEVELS, PAT_NOISE} bin_pattern_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [POWER_W-1:0] req_bin_power;
   logic req_last_bin;
   logic rsp_valid;
   logic rsp_ready;
   logic [CHAN_IDX_W-1:0] rsp_channel_index;
   logic signed [POWER_W-1:0] rsp_channel_power;
   logic rsp_above_threshold;
   logic signed [CHAN_W-1:0] rsp_strongest_channel;
   logic rsp_decision_final;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int error_count;
   int pending_count;
   int result_count;
   int edge_count;
   int items_sent;
   int frames_sent;
   int settings_used;
   bit steady;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   spectrum_channel_energy_detector_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_bin_power         (req_bin_power),
      .req_last_bin          (req_last_bin),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_channel_index     (rsp_channel_index),
      .rsp_channel_power     (rsp_channel_power),
      .rsp_above_threshold   (rsp_above_threshold),
      .rsp_strongest_channel (rsp_strongest_channel),
      .rsp_decision_final    (rsp_decision_final),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   energy_detector_checker checker_i (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_bin_power         (req_bin_power),
      .req_last_bin          (req_last_bin),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_channel_index     (rsp_channel_index),
      .rsp_channel_power     (rsp_channel_power),
      .rsp_above_threshold   (rsp_above_threshold),
      .rsp_strongest_channel (rsp_strongest_channel),
      .rsp_decision_final    (rsp_decision_final),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .error_count           (error_count),
      .pending_count         (pending_count),
      .result_count          (result_count),
      .edge_count            (edge_count)
   );

   // sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 75) begin
         return 0;
      end
      if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   task automatic send_bin(input logic signed [POWER_W-1:0] p, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_bin_power <= p;
      req_last_bin  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // one frame of bins, last_bin on the final one; levels change at main window starts
   task automatic run_frame(input int length, input bin_pattern_type pattern, input int base,
                            input int spread, input int noise);
      int level;
      int wnd;
      int value;
      level = base;
      wnd   = 0;
      for (int pos = 0; pos < length; pos++) begin
         if (pos >= MAIN_START && (pos - MAIN_START) % WINDOW == 0) begin
            wnd++;
            if (pattern == PAT_RAMP) begin
               level = base + wnd * spread;
            end else if (pattern == PAT_LEVELS) begin
               level = base + spread * int'($urandom_range(0, 3));
            end
         end
         if (pattern == PAT_NOISE) begin
            value = int'($urandom_range(0, 65535)) - 32768;
         end else if (noise > 0) begin
            value = level + int'($urandom_range(0, 2 * noise)) - noise;
         end else begin
            value = level;
         end
         if (value > 32767) begin
            value = 32767;
         end else if (value < -32768) begin
            value = -32768;
         end
         send_bin(POWER_W'(value), pos == length - 1);
      end
      frames_sent++;
   endtask

   // drain the detector, then load all three control registers
   task automatic set_detector(input int fl, input int mt, input int et);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FRAME_LENGTH;
      csr_write_data   <= {4'($urandom_range(0, 15)), 12'(fl)};
      @(posedge clock);
      csr_index      <= CSR_MAIN_THRESHOLD;
      csr_write_data <= 16'(mt);
      @(posedge clock);
      csr_index      <= CSR_EDGE_THRESHOLD;
      csr_write_data <= 16'(et);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // response side stalls: mostly short, a few long, some long ready stretches
   initial begin
      int roll;
      int span;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            rsp_ready <= 1'b1;
            span = $urandom_range(100, 300);
         end else if (roll < 60) begin
            rsp_ready <= 1'b1;
            span = $urandom_range(1, 30);
         end else if (roll < 90) begin
            rsp_ready <= 1'b0;
            span = $urandom_range(1, 3);
         end else if (roll < 97) begin
            rsp_ready <= 1'b0;
            span = $urandom_range(4, 20);
         end else begin
            rsp_ready <= 1'b0;
            span = $urandom_range(30, 60);
         end
         repeat (span - 1) @(posedge clock);
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t ns: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int roll;
      int fl;
      int mt;
      int et;
      int length;
      int remaining;
      bin_pattern_type pattern;
      int base;
      int spread;
      int noise;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_bin_power    = '0;
      req_last_bin     = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FRAME_LENGTH;
      csr_write_data   = '0;
      steady           = 1'b0;
      items_sent       = 0;
      frames_sent      = 0;
      settings_used    = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full-scale frame (all windows tie), floor frame, one-bin frame
      run_frame(511, PAT_FIXED, 32767, 0, 0);
      run_frame(100, PAT_FIXED, -32768, 0, 0);
      run_frame(1, PAT_FIXED, 0, 0, 0);

      // edge window closes on the same bin as channel twelve
      set_detector(430, -3000, -3000);
      steady = 1'b1;
      run_frame(430, PAT_LEVELS, -6000, 2000, 500);
      steady = 1'b0;

      // random settings and frames until the request budget is spent
      while (items_sent < TOTAL_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            fl = $urandom_range(92, 300);
         end else if (roll < 65) begin
            fl = $urandom_range(0, 91);
         end else if (roll < 85) begin
            fl = 430;
         end else begin
            fl = 511;
         end
         if ($urandom_range(0, 99) < 80) begin
            mt = -12000 + int'($urandom_range(0, 24000));
            et = -12000 + int'($urandom_range(0, 24000));
         end else begin
            mt = int'($urandom_range(0, 65535)) - 32768;
            et = int'($urandom_range(0, 65535)) - 32768;
         end
         set_detector(fl, mt, et);

         repeat ($urandom_range(1, 3)) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               length = (fl > 0) ? fl : 1;
            end else if (roll < 85) begin
               length = $urandom_range(1, (fl > 1) ? fl - 1 : 1);
            end else begin
               length = fl + $urandom_range(1, 300);
            end
            remaining = TOTAL_ITEMS - items_sent;
            if (length > remaining) begin
               length = remaining;
            end
            steady = ($urandom_range(0, 4) == 0);
            roll   = $urandom_range(0, 99);
            noise  = 0;
            spread = 0;
            if (roll < 55) begin
               pattern = PAT_LEVELS;
               base    = -14000 + int'($urandom_range(0, 20000));
               spread  = $urandom_range(0, 3000);
               noise   = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 2000)) : 0;
            end else if (roll < 70) begin
               pattern = PAT_NOISE;
               base    = 0;
            end else if (roll < 85) begin
               pattern = PAT_RAMP;
               base    = -15000 + int'($urandom_range(0, 5000));
               spread  = $urandom_range(200, 2500);
            end else begin
               // constant level right at a threshold checks the strict compare
               pattern = PAT_FIXED;
               base    = (($urandom_range(0, 1) == 1) ? mt : et) + int'($urandom_range(0, 2)) - 1;
            end
            if (length > 0) begin
               run_frame(length, pattern, base, spread, noise);
            end
         end
      end

      // drain and let the pipeline settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES + 2) @(posedge clock);

      $display("run covered %0d bin requests in %0d frames under %0d register settings",
               items_sent, frames_sent, settings_used);
      $display("checked %0d window results, %0d of them edge decisions",
               result_count, edge_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
